// ----- sv/linear_probe_hash_table_assert.svh -----
// assertion macros for the linear probe hash table
// included by the top level, needs clk and arst_n in scope
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`ifndef SYNTH
`define LPHT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");
`define LPHT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");
`else
`define LPHT_ASSERT_SAME(lbl, ante, cons)
`define LPHT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- sv/lpht_pkg.sv -----
// shared types and constants of the linear probe hash table
// no dependencies
`timescale 1ns / 1ps
package lpht_pkg;
	localparam int DEFAULT_SLOTS      = 64;
	localparam int DEFAULT_KEY_BITS   = 32;
	localparam int DEFAULT_VALUE_BITS = 32;
	localparam int HASH_SHIFT         = 13;
	localparam int SIZE_BITS          = 7;
	localparam int MAX_SIZE           = (1 << SIZE_BITS) - 1;
	localparam int KEY_PORT_BITS      = 32;
	localparam int VALUE_PORT_BITS    = 32;
	localparam int DIGIT_BITS         = 4;
	localparam logic [SIZE_BITS-1:0] RESET_SIZE = SIZE_BITS'(50);

	localparam logic [1:0] ACT_PUT    = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_GET    = 2'd2;

	localparam logic [1:0] STATUS_DONE    = 2'd0;
	localparam logic [1:0] STATUS_FULL    = 2'd1;
	localparam logic [1:0] STATUS_MISSING = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_HASH,
		S_PROBE,
		S_FINISH
	} lpht_state_t;

	typedef struct packed {
		logic write_pair;
		logic set_used;
		logic clr_used;
	} lpht_wr_ctl_t;
endpackage

// ----- sv/lpht_rem_unit.sv -----
// iterative remainder unit: dividend mod divisor, DIGIT_BITS quotient bits per cycle
// depends on lpht_pkg
`timescale 1ns / 1ps
module lpht_rem_unit #(
	parameter int IN_BITS = 45,
	parameter int NW      = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [IN_BITS-1:0] dividend,
	input  logic [NW-1:0]      divisor,
	output logic               busy,
	output logic [NW-1:0]      rem
);
	import lpht_pkg::*;

	localparam int STEPS = (IN_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int PW    = STEPS * DIGIT_BITS;
	localparam int CW    = $clog2(STEPS + 1);

	logic [PW-1:0] shreg_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] rem_d;
	logic [CW-1:0] cnt_q;

	// restoring remainder, one shift-compare-subtract per bit
	always_comb begin
		logic [NW:0]   t;
		logic [NW-1:0] r;
		r = rem_q;
		for (int i = 0; i < DIGIT_BITS; i++) begin
			t = {r, shreg_q[PW-1-i]};
			if (t >= {1'b0, divisor})
				t = t - {1'b0, divisor};
			r = t[NW-1:0];
		end
		rem_d = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shreg_q <= PW'(dividend);
			rem_q   <= '0;
		end else if (cnt_q != '0) begin
			shreg_q <= shreg_q << DIGIT_BITS;
			rem_q   <= rem_d;
		end
	end

	assign busy = (cnt_q != '0);
	assign rem  = rem_q;
endmodule

// ----- sv/lpht_store.sv -----
// slot storage: valid bits in flops, key and value memories with registered read
// depends on lpht_pkg
`timescale 1ns / 1ps
module lpht_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int KW    = 32,
	parameter int VW    = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [AW-1:0]          rd_addr,
	output logic                   rd_used,
	output logic [KW-1:0]          rd_key,
	output logic [VW-1:0]          rd_value,
	input  lpht_pkg::lpht_wr_ctl_t wr_ctl,
	input  logic [AW-1:0]          wr_addr,
	input  logic [KW-1:0]          wr_key,
	input  logic [VW-1:0]          wr_value
);
	import lpht_pkg::*;

	logic [DEPTH-1:0] used_q;
	logic [KW-1:0]    key_mem [DEPTH];
	logic [VW-1:0]    value_mem [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			rd_used <= 1'b0;
		end else begin
			if (wr_ctl.set_used)
				used_q[wr_addr] <= 1'b1;
			else if (wr_ctl.clr_used)
				used_q[wr_addr] <= 1'b0;
			rd_used <= used_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ctl.write_pair) begin
			key_mem[wr_addr]   <= wr_key;
			value_mem[wr_addr] <= wr_value;
		end
		rd_key   <= key_mem[rd_addr];
		rd_value <= value_mem[rd_addr];
	end
endmodule

// ----- sv/linear_probe_hash_table.sv -----
// linear probe hash table, top level: sequencer, hash, probe walk and result register
// depends on lpht_pkg, lpht_rem_unit, lpht_store, linear_probe_hash_table_assert.svh
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------
//   cfg      | cfg_valid / cfg_ready  | cfg_data (table_size)
//   req      | req_valid / req_ready  | action, key, value
//   rsp      | rsp_valid / rsp_ready  | status, found_value
//
// an item goes through the hash, then probes p slots, p being 1 to the active size:
// the home slot comes from the remainder unit, DIGIT_BITS bits a cycle over the
// (KW + 13)-bit hash, KW being KEY_BITS capped at the port width, then one slot
// is read per cycle from the key/value memory, each checked when its read returns
// reset clears every valid bit at once and sets table_size to 50
// req_ready is high only while the sequencer is idle; a finished item waits in
// the finish state until the response register is free
`timescale 1ns / 1ps
module linear_probe_hash_table #(
	parameter int SLOTS      = lpht_pkg::DEFAULT_SLOTS,
	parameter int KEY_BITS   = lpht_pkg::DEFAULT_KEY_BITS,
	parameter int VALUE_BITS = lpht_pkg::DEFAULT_VALUE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lpht_pkg::SIZE_BITS-1:0]       cfg_data,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  logic [1:0]                           action,
	input  logic [lpht_pkg::KEY_PORT_BITS-1:0]   key,
	input  logic [lpht_pkg::VALUE_PORT_BITS-1:0] value,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output logic [1:0]                           status,
	output logic [lpht_pkg::VALUE_PORT_BITS-1:0] found_value
);
	import lpht_pkg::*;

	// table_size never exceeds MAX_SIZE, so deeper storage is never reached
	localparam int DEPTH = (SLOTS < MAX_SIZE) ? SLOTS : MAX_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = $clog2(DEPTH + 1);
	localparam int KW    = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;
	localparam int VW    = (VALUE_BITS < VALUE_PORT_BITS) ? VALUE_BITS : VALUE_PORT_BITS;
	localparam int HW    = KW + HASH_SHIFT;

	lpht_state_t state_q, state_d;

	logic [SIZE_BITS-1:0] table_size_q;
	logic [NW-1:0]        n_c;

	// latched request
	logic [1:0]    act_q;
	logic [KW-1:0] key_q;
	logic [VW-1:0] val_q;

	// probe walk
	logic [AW-1:0] pos_q;
	logic [AW-1:0] pos_next;
	logic [NW-1:0] pos_inc;
	logic [NW-1:0] cnt_q;
	logic          chk_valid_s1;
	logic [AW-1:0] chk_addr_s1;
	logic          chk_last_s1;

	// sequencer outputs
	logic         req_accept;
	logic         probe_init;
	logic         issue;
	logic         res_load;
	logic         rsp_load;
	logic [1:0]   res_status_d;
	logic [VW-1:0] res_found_d;
	lpht_wr_ctl_t wr_ctl;

	// result holding and response register
	logic [1:0]    res_status_q;
	logic [VW-1:0] res_found_q;
	logic          rsp_valid_q;
	logic [1:0]    status_q;
	logic [VW-1:0] found_q;

	// remainder unit and store
	logic [HW-1:0] hash_c;
	logic          div_busy;
	logic [NW-1:0] div_rem;
	logic          rd_used;
	logic [KW-1:0] rd_key;
	logic [VW-1:0] rd_value;
	logic          key_match;

	// terms watched by the checks
	logic          slot_wr;
	logic          full_wait;

	// size register, size zero acts as one, above the depth acts as the depth
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			table_size_q <= RESET_SIZE;
		else if (cfg_valid && cfg_ready)
			table_size_q <= cfg_data;
	end

	always_comb begin
		if (table_size_q == '0)
			n_c = NW'(1);
		else if (table_size_q > SIZE_BITS'(DEPTH))
			n_c = NW'(DEPTH);
		else
			n_c = table_size_q[NW-1:0];
	end

	// home slot hash, taken straight from the ports at accept
	assign hash_c = HW'(key[KW-1:0]) ^ (HW'(key[KW-1:0]) << HASH_SHIFT);

	assign req_ready  = (state_q == S_IDLE);
	assign req_accept = req_valid && req_ready;

	lpht_rem_unit #(
		.IN_BITS (HW),
		.NW      (NW)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req_accept),
		.dividend (hash_c),
		.divisor  (n_c),
		.busy     (div_busy),
		.rem      (div_rem)
	);

	lpht_store #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.KW    (KW),
		.VW    (VW)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (pos_q),
		.rd_used  (rd_used),
		.rd_key   (rd_key),
		.rd_value (rd_value),
		.wr_ctl   (wr_ctl),
		.wr_addr  (chk_addr_s1),
		.wr_key   (key_q),
		.wr_value (val_q)
	);

	assign key_match = rd_used && (rd_key == key_q);

	// step forward with wrap at the active size
	assign pos_inc  = NW'(pos_q) + NW'(1);
	assign pos_next = (pos_inc == n_c) ? '0 : pos_inc[AW-1:0];

	// sequencer
	always_comb begin
		state_d      = state_q;
		probe_init   = 1'b0;
		issue        = 1'b0;
		res_load     = 1'b0;
		rsp_load     = 1'b0;
		res_status_d = STATUS_DONE;
		res_found_d  = '0;
		wr_ctl       = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (action inside {ACT_PUT, ACT_REMOVE, ACT_GET}) begin
						state_d = S_HASH;
					end else begin
						// unknown action: no state change, done with zero value
						state_d  = S_FINISH;
						res_load = 1'b1;
					end
				end
			end
			S_HASH: begin
				if (!div_busy) begin
					probe_init = 1'b1;
					state_d    = S_PROBE;
				end
			end
			S_PROBE: begin
				// keep reading ahead until one lap has been issued
				issue = (cnt_q != n_c);
				if (chk_valid_s1) begin
					if (act_q == ACT_PUT) begin
						if (!rd_used) begin
							wr_ctl.write_pair = 1'b1;
							wr_ctl.set_used   = 1'b1;
							res_load          = 1'b1;
							state_d           = S_FINISH;
						end else if (chk_last_s1) begin
							res_status_d = STATUS_FULL;
							res_load     = 1'b1;
							state_d      = S_FINISH;
						end
					end else begin
						if (key_match) begin
							if (act_q == ACT_REMOVE)
								wr_ctl.clr_used = 1'b1;
							else
								res_found_d = rd_value;
							res_load = 1'b1;
							state_d  = S_FINISH;
						end else if (chk_last_s1) begin
							res_status_d = STATUS_MISSING;
							res_load     = 1'b1;
							state_d      = S_FINISH;
						end
					end
				end
			end
			S_FINISH: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// request capture
	always_ff @(posedge clk) begin
		if (req_accept) begin
			act_q <= action;
			key_q <= key[KW-1:0];
			val_q <= value[VW-1:0];
		end
	end

	// probe counters and the check stage behind the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			chk_valid_s1 <= 1'b0;
		end else begin
			if (probe_init)
				cnt_q <= '0;
			else if (issue)
				cnt_q <= cnt_q + NW'(1);
			chk_valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (probe_init)
			pos_q <= div_rem[AW-1:0];
		else if (issue)
			pos_q <= pos_next;
		if (issue) begin
			chk_addr_s1 <= pos_q;
			chk_last_s1 <= ((cnt_q + NW'(1)) == n_c);
		end
	end

	// result holding register
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_status_q <= res_status_d;
			res_found_q  <= res_found_d;
		end
	end

	// response register, freed when the item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (rsp_load)
			rsp_valid_q <= 1'b1;
		else if (rsp_ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			status_q <= res_status_q;
			found_q  <= res_found_q;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign found_value = VALUE_PORT_BITS'(found_q);

	// slot valid bit changes, and a full result waiting to go out
	assign slot_wr   = wr_ctl.set_used || wr_ctl.clr_used;
	assign full_wait = (state_q == S_FINISH) && (res_status_q == STATUS_FULL);

	`include "linear_probe_hash_table_assert.svh"

	// an accepted item always takes the sequencer out of idle
	`LPHT_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
	// the walk never issues more than one lap
	`LPHT_ASSERT_SAME(a_lap_bound, state_q == S_PROBE, cnt_q <= n_c)
	// slot writes come only from a checked slot during the walk
	`LPHT_ASSERT_SAME(a_write_in_walk, slot_wr, state_q == S_PROBE && chk_valid_s1)
	// full is reported for puts only
	`LPHT_ASSERT_SAME(a_full_on_put, full_wait, act_q == ACT_PUT)
endmodule

// ----- bench/tb_linear_probe_hash_table.sv -----
// testbench for linear_probe_hash_table: directed and random put/remove/get traffic
// over several table sizes, checked against a behavioral copy of the slot store
// depends on lpht_pkg and linear_probe_hash_table
`timescale 1ns / 1ps
module tb_linear_probe_hash_table;
	import lpht_pkg::*;

	// the package names no code for the fourth action, which the block ignores
	localparam logic [1:0] ACT_IGNORED = 2'd3;

	localparam int CYCLE_LIMIT      = 900000;
	localparam int LONG_HOLD_AT     = 30;   // reply count that starts the long receiver stall
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES     = 120;  // hash plus a full probe lap, with margin
	localparam int HOT_KEYS         = 12;

	typedef struct packed {
		logic [1:0]                 act;
		logic [KEY_PORT_BITS-1:0]   key;
		logic [VALUE_PORT_BITS-1:0] data;
	} table_req_t;

	typedef struct packed {
		logic [1:0]                 status;
		logic [VALUE_PORT_BITS-1:0] found;
	} table_reply_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [SIZE_BITS-1:0]       cfg_data = '0;
	logic                       req_valid = 1'b0;
	logic                       req_ready;
	logic [1:0]                 action = '0;
	logic [KEY_PORT_BITS-1:0]   key = '0;
	logic [VALUE_PORT_BITS-1:0] value = '0;
	logic                       rsp_valid;
	logic                       rsp_ready = 1'b0;
	logic [1:0]                 status;
	logic [VALUE_PORT_BITS-1:0] found_value;

	// shadow of the slot store and the size register
	logic [SIZE_BITS-1:0]       size_reg;
	logic                       slot_used [DEFAULT_SLOTS];
	logic [KEY_PORT_BITS-1:0]   slot_key [DEFAULT_SLOTS];
	logic [VALUE_PORT_BITS-1:0] slot_value [DEFAULT_SLOTS];

	table_req_t   queued_reqs [$];  // items waiting for the driver
	table_reply_t replies_due [$];  // replies owed by the block, oldest first
	table_req_t   cur_req;          // item currently on the request port

	logic [KEY_PORT_BITS-1:0] hot_keys [HOT_KEYS];

	int mismatch_count = 0;
	int replies_seen   = 0;
	int cycle_count    = 0;

	linear_probe_hash_table uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.action     (action),
		.key        (key),
		.value      (value),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.status     (status),
		.found_value(found_value)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// apply one request to the shadow store and return the reply it earns
	function automatic table_reply_t table_outcome(table_req_t r);
		table_reply_t res;
		logic [63:0]  wide;
		int           n;
		int           pos;
		int           hit;
		// size 0 acts as 1, anything past the slot count as the slot count
		n = int'(size_reg);
		if (n < 1) n = 1;
		if (n > DEFAULT_SLOTS) n = DEFAULT_SLOTS;
		// home slot: (k xor k<<13) mod n on a 64-bit value
		wide = {32'd0, r.key};
		wide = wide ^ (wide << HASH_SHIFT);
		pos = int'(wide % 64'(n));
		res.status = STATUS_DONE;
		res.found = '0;
		// one lap from home with wrap; put wants a free slot, the rest a used slot with the key
		hit = -1;
		for (int i = 0; i < n; i++) begin
			if (hit < 0) begin
				if (r.act == ACT_PUT) begin
					if (!slot_used[pos]) hit = pos;
				end else if (slot_used[pos] && slot_key[pos] == r.key) begin
					hit = pos;
				end
			end
			pos = (pos + 1 == n) ? 0 : pos + 1;
		end
		case (r.act)
			ACT_PUT: begin
				if (hit < 0) begin
					res.status = STATUS_FULL;
				end else begin
					slot_used[hit] = 1'b1;
					slot_key[hit] = r.key;
					slot_value[hit] = r.data;
				end
			end
			ACT_REMOVE: begin
				if (hit < 0) res.status = STATUS_MISSING;
				else slot_used[hit] = 1'b0;
			end
			ACT_GET: begin
				if (hit < 0) res.status = STATUS_MISSING;
				else res.found = slot_value[hit];
			end
			default: begin
				// unknown action: no state change, zero reply
			end
		endcase
		return res;
	endfunction

	task automatic push_req(input logic [1:0] act, input logic [31:0] k, input logic [31:0] d);
		table_req_t r;
		r.act = act;
		r.key = k;
		r.data = d;
		queued_reqs.push_back(r);
	endtask

	// sender pause: hold off until every item is taken and every reply is back
	task automatic wait_drained();
		do @(posedge clk);
		while (queued_reqs.size() != 0 || req_valid || replies_due.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	// size write, only issued while the block is idle
	task automatic write_size(input logic [SIZE_BITS-1:0] sz);
		@(negedge clk);
		cfg_data <= sz;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!(cfg_valid && cfg_ready));
		size_reg = sz;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// random traffic: mostly a small pool of keys so that gets and removes hit,
	// with some fresh keys, a few ignored actions and a per-phase put share
	task automatic fill_random(input int count, input int put_pct);
		table_req_t r;
		int         roll;
		for (int i = 0; i < HOT_KEYS; i++) begin
			case ($urandom_range(0, 9))
				0: hot_keys[i] = '0;
				1: hot_keys[i] = '1;
				default: hot_keys[i] = $urandom();
			endcase
		end
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < put_pct) r.act = ACT_PUT;
			else if (roll < put_pct + (97 - put_pct) / 2) r.act = ACT_REMOVE;
			else if (roll < 97) r.act = ACT_GET;
			else r.act = ACT_IGNORED;
			if ($urandom_range(0, 4) != 0) r.key = hot_keys[$urandom_range(0, HOT_KEYS - 1)];
			else r.key = $urandom();
			case ($urandom_range(0, 7))
				0: r.data = '0;
				1: r.data = '1;
				default: r.data = $urandom();
			endcase
			queued_reqs.push_back(r);
		end
	endtask

	initial begin : stimulus
		logic [SIZE_BITS-1:0] phase_sizes [14];
		logic [SIZE_BITS-1:0] sz;
		phase_sizes = '{7'd64, 7'd127, 7'd1, 7'd2, 7'd3, 7'd0, 7'd9,
			7'd64, 7'd17, 7'd50, 7'd0, 7'd0, 7'd63, 7'd64};
		size_reg = RESET_SIZE;
		for (int i = 0; i < DEFAULT_SLOTS; i++) begin
			slot_used[i] = 1'b0;
			slot_key[i] = '0;
			slot_value[i] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset size: lookups on an empty table, extreme keys and values,
		// a duplicate put, remove of the first copy, an ignored action
		push_req(ACT_GET, 32'h0000_0000, 32'h0);
		push_req(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0);
		push_req(ACT_PUT, 32'h0000_0000, 32'h0000_0000);
		push_req(ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_req(ACT_PUT, 32'h0000_0000, 32'hA5A5_5A5A);
		push_req(ACT_GET, 32'h0000_0000, 32'h0);
		push_req(ACT_GET, 32'hFFFF_FFFF, 32'h0);
		push_req(ACT_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF);
		push_req(ACT_GET, 32'h0000_0000, 32'h0);
		push_req(ACT_IGNORED, 32'h0000_0000, 32'hFFFF_FFFF);
		push_req(ACT_GET, 32'h1234_5678, 32'h0);
		wait_drained();

		// size zero acts as one slot: second put is full, the rest of the
		// earlier entries sit out of reach
		write_size(7'd0);
		push_req(ACT_PUT, 32'h0000_0007, 32'h0000_0001);
		push_req(ACT_PUT, 32'h0000_0008, 32'h0000_0002);
		push_req(ACT_GET, 32'h0000_0008, 32'h0);
		push_req(ACT_GET, 32'h0000_0007, 32'h0);
		push_req(ACT_REMOVE, 32'h0000_0007, 32'h0);
		push_req(ACT_PUT, 32'h0000_0008, 32'h0000_0002);
		wait_drained();

		// size above the slot count is clamped; the key in slot 0 is found by
		// wrapping around from its home, and the old entries come back into reach
		write_size(7'd127);
		push_req(ACT_GET, 32'h0000_0008, 32'h0);
		push_req(ACT_PUT, 32'h8000_0000, 32'h0000_0001);
		push_req(ACT_GET, 32'h8000_0000, 32'h0);
		push_req(ACT_IGNORED, 32'hFFFF_FFFF, 32'h0);
		wait_drained();

		// random phases over many sizes; contents carry over from phase to phase
		for (int p = 0; p < 14; p++) begin
			sz = (p == 10 || p == 11) ? SIZE_BITS'($urandom_range(0, 127)) : phase_sizes[p];
			write_size(sz);
			fill_random(95, $urandom_range(25, 75));
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// request driver: note each item taken at the rising edge, drive at the falling edge
	always begin : req_driver
		logic took;
		int   req_gap;
		int   req_count;
		logic req_calm;
		req_gap = 0;
		req_count = 0;
		req_calm = 1'b0;
		forever begin
			@(posedge clk);
			took = arst_n && req_valid && req_ready;
			if (took) begin
				replies_due.push_back(table_outcome(cur_req));
				req_count++;
				// every so often switch between idling and back-to-back items
				if (req_count % 40 == 0) req_calm = ($urandom_range(0, 3) == 0);
				req_gap = req_calm ? 0 : $urandom_range(0, 8);
			end
			@(negedge clk);
			if (req_valid && !took) begin
				// item still on offer, payload held
			end else if (req_gap > 0) begin
				req_gap--;
				req_valid <= 1'b0;
			end else if (queued_reqs.size() != 0) begin
				cur_req = queued_reqs.pop_front();
				action <= cur_req.act;
				key <= cur_req.key;
				value <= cur_req.data;
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// reply monitor: check at the rising edge, decide the stall at the falling edge
	always begin : rsp_monitor
		table_reply_t want;
		logic         took;
		int           rsp_stall;
		logic         rsp_calm;
		rsp_stall = 0;
		rsp_calm = 1'b0;
		forever begin
			@(posedge clk);
			took = arst_n && rsp_valid && rsp_ready;
			if (took) begin
				if (replies_due.size() == 0) begin
					$display("%0t ns: reply with nothing due, status %0d found_value %h",
						$time, status, found_value);
					mismatch_count++;
				end else begin
					want = replies_due.pop_front();
					if (status !== want.status) begin
						$display("%0t ns: status expected %0d, actual %0d",
							$time, want.status, status);
						mismatch_count++;
					end
					if (found_value !== want.found) begin
						$display("%0t ns: found_value expected %h, actual %h",
							$time, want.found, found_value);
						mismatch_count++;
					end
				end
				replies_seen++;
				if (replies_seen % 40 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
				// one long hold-off while the sender keeps offering, so the block backs up
				if (replies_seen == LONG_HOLD_AT) rsp_stall = LONG_HOLD_CYCLES;
				else rsp_stall = rsp_calm ? 0 : $urandom_range(0, 8);
			end
			@(negedge clk);
			if (rsp_stall > 0) begin
				rsp_stall--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t ns: timeout after %0d cycles", $time, cycle_count);
			$display("end of test: mismatches");
			$finish;
		end
	end
endmodule
